/* src/dmbmp_pkg.sv */
// ---------------------------------------------------------------------------
// dmbmp_pkg: shared types and constants for the display mode picker
// Score encoding, configuration register indexes and refresh window checks.
// ---------------------------------------------------------------------------
`default_nettype none

package dmbmp_pkg;

  localparam int unsigned SCORE_W = 28;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned RATE_W  = 22;
  localparam int unsigned OIDX_W  = 6;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [DIM_W-1:0]          dim_t;
  typedef logic [RATE_W-1:0]         rate_t;

  typedef enum logic [1:0] {
    CFG_TARGET_WIDTH   = 2'd0,
    CFG_TARGET_HEIGHT  = 2'd1,
    CFG_TARGET_REFRESH = 2'd2
  } cfg_idx_t;

  localparam score_t SCORE_NONE      = -28'sd1;
  localparam score_t SCORE_EXACT     = 28'sd100000000;
  localparam score_t SCORE_NEAR      = 28'sd95000000;
  localparam score_t SCORE_DBL_EXACT = 28'sd90000000;
  localparam score_t SCORE_DBL_NEAR  = 28'sd85000000;
  localparam score_t SCORE_PREF_AUTO = 28'sd83000000;
  localparam score_t SCORE_FAST_BASE = 28'sd80000000;
  localparam score_t SCORE_PREF_ONLY = 28'sd10000000;

  localparam rate_t  RATE_SAT   = 22'd2999999;
  localparam logic [7:0] WIN_TIGHT = 8'd10;
  localparam logic [7:0] WIN_LOOSE = 8'd100;

  // True when r lies within +-win of t; 25 bits keep the sums from wrapping.
  function automatic logic in_window(input logic [23:0] r, input logic [23:0] t,
                                     input logic [7:0] win);
    logic [24:0] r_hi;
    logic [24:0] t_hi;
    begin
      r_hi = {1'b0, r} + {17'd0, win};
      t_hi = {1'b0, t} + {17'd0, win};
      in_window = (r_hi >= {1'b0, t}) && ({1'b0, r} <= t_hi);
    end
  endfunction

endpackage

`default_nettype wire

/* src/display_mode_best_match_picker_unit.sv */
// ---------------------------------------------------------------------------
// display_mode_best_match_picker_unit: best display mode selector
// Scores one mode descriptor per transfer and reports the best one at list end.
// ---------------------------------------------------------------------------
// A mode is registered on input, then scored and merged into the running best;
// a list's result is registered as its last mode leaves the input register.
// Throughput: one mode per cycle, set by scoring, unless a last mode stalls.
// A last mode waits in the input register only while a prior result is held.
// Reset (rst_n low, synchronous): targets to 0, best score -1, index and
// position to 0, both stages empty.
`default_nettype none

module display_mode_best_match_picker_unit
  import dmbmp_pkg::*;
#(
  parameter int unsigned MAX_MODES = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,

  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [21:0]   cfg_data,

  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [13:0]   in_mode_width,
  input  wire logic [13:0]   in_mode_height,
  input  wire logic [21:0]   in_mode_refresh,
  input  wire logic          in_is_preferred,
  input  wire logic          in_is_interlaced,
  input  wire logic          in_last_mode,

  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [5:0]         out_best_index,
  output logic               out_found,
  output logic signed [27:0] out_top_score
);

  localparam int unsigned IDX_W = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
  localparam int unsigned POS_W = $clog2(MAX_MODES + 1);

  // configuration
  dim_t  tgt_w_r, tgt_h_r;
  rate_t tgt_rf_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_w_r  <= '0;
      tgt_h_r  <= '0;
      tgt_rf_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TARGET_WIDTH:   tgt_w_r  <= cfg_data[DIM_W-1:0];
        CFG_TARGET_HEIGHT:  tgt_h_r  <= cfg_data[DIM_W-1:0];
        CFG_TARGET_REFRESH: tgt_rf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic  s1_valid_r;
  dim_t  s1_w_r, s1_h_r;
  rate_t s1_rf_r;
  logic  s1_pref_r, s1_intl_r, s1_last_r;
  logic  advance;

  logic  out_valid_r;

  // a last mode needs a free result register; other modes always move on
  assign advance  = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_w_r    <= in_mode_width;
      s1_h_r    <= in_mode_height;
      s1_rf_r   <= in_mode_refresh;
      s1_pref_r <= in_is_preferred;
      s1_intl_r <= in_is_interlaced;
      s1_last_r <= in_last_mode;
    end
  end

  // scoring
  score_t      score;
  score_t      size_score;
  logic [23:0] rm_ext, tgt_ext, tgt_dbl;
  rate_t       rm_sat;

  always_comb begin
    rm_ext  = {2'b00, s1_rf_r};
    tgt_ext = {2'b00, tgt_rf_r};
    tgt_dbl = {1'b0, tgt_rf_r, 1'b0};
    rm_sat  = (s1_rf_r >= RATE_SAT) ? RATE_SAT : s1_rf_r;

    if (tgt_rf_r == '0) begin
      size_score = s1_pref_r ? SCORE_PREF_AUTO
                             : SCORE_FAST_BASE + score_t'({6'd0, rm_sat});
    end else if (in_window(rm_ext, tgt_ext, WIN_TIGHT)) begin
      size_score = SCORE_EXACT;
    end else if (in_window(rm_ext, tgt_ext, WIN_LOOSE)) begin
      size_score = SCORE_NEAR;
    end else if (in_window(rm_ext, tgt_dbl, WIN_TIGHT)) begin
      size_score = SCORE_DBL_EXACT;
    end else if (in_window(rm_ext, tgt_dbl, WIN_LOOSE)) begin
      size_score = SCORE_DBL_NEAR;
    end else begin
      size_score = SCORE_NONE;
    end

    if (s1_intl_r) begin
      score = SCORE_NONE;
    end else begin
      score = (s1_w_r == tgt_w_r && s1_h_r == tgt_h_r) ? size_score : SCORE_NONE;
      // preferred mode with nothing else going for it
      if (score == SCORE_NONE && s1_pref_r) begin
        score = SCORE_PREF_ONLY;
      end
    end
  end

  // running best
  score_t           top_score_r, top_score_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             in_range;

  always_comb begin
    in_range      = pos_r < POS_W'(MAX_MODES);
    top_score_nxt = top_score_r;
    best_idx_nxt  = best_idx_r;
    pos_nxt       = pos_r;
    if (in_range) begin
      if (score > top_score_r) begin
        top_score_nxt = score;
        best_idx_nxt  = pos_r[IDX_W-1:0];
      end
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_score_r <= SCORE_NONE;
      best_idx_r  <= '0;
      pos_r       <= '0;
    end else if (advance) begin
      if (s1_last_r) begin
        // start a new list
        top_score_r <= SCORE_NONE;
        best_idx_r  <= '0;
        pos_r       <= '0;
      end else begin
        top_score_r <= top_score_nxt;
        best_idx_r  <= best_idx_nxt;
        pos_r       <= pos_nxt;
      end
    end
  end

  // result register
  logic [31:0] idx_wide;
  logic        hit;

  assign idx_wide = 32'(best_idx_nxt);
  assign hit      = !top_score_nxt[SCORE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_best_index <= hit ? idx_wide[OIDX_W-1:0] : '0;
      out_found      <= hit;
      out_top_score  <= hit ? top_score_nxt : SCORE_NONE;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the display mode best match picker
// Sends lists of random and hand-picked mode descriptors under several target
// settings, scores them in a local predictor and checks each list's pick.
// ---------------------------------------------------------------------------

module tb_top;
  import dmbmp_pkg::*;

  localparam int LIST_CAP    = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 4;
  localparam int RATE_MAX    = 4194303;
  localparam int RATE_CLAMP  = 2999999;

  // Score levels
  localparam int PTS_NONE     = -1;
  localparam int PTS_EXACT    = 100000000;
  localparam int PTS_NEAR     = 95000000;
  localparam int PTS_DBL      = 90000000;
  localparam int PTS_DBL_NEAR = 85000000;
  localparam int PTS_AUTO_PRF = 83000000;
  localparam int PTS_FASTEST  = 80000000;
  localparam int PTS_PREF     = 10000000;

  // Register index with no register behind it
  localparam logic [1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    dim_t  w;
    dim_t  h;
    rate_t r;
    logic  pref;
    logic  intl;
    logic  last;
  } mode_t;

  typedef struct packed {
    logic [5:0] idx;
    logic       found;
    score_t     score;
  } pick_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [1:0]    cfg_index;
  logic [21:0]   cfg_data;
  logic          in_valid;
  logic          in_ready;
  logic [13:0]   in_mode_width;
  logic [13:0]   in_mode_height;
  logic [21:0]   in_mode_refresh;
  logic          in_is_preferred;
  logic          in_is_interlaced;
  logic          in_last_mode;
  logic          out_valid;
  logic          out_ready;
  logic [5:0]    out_best_index;
  logic          out_found;
  logic signed [27:0] out_top_score;

  display_mode_best_match_picker_unit #(
    .MAX_MODES(LIST_CAP)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode_width    (in_mode_width),
    .in_mode_height   (in_mode_height),
    .in_mode_refresh  (in_mode_refresh),
    .in_is_preferred  (in_is_preferred),
    .in_is_interlaced (in_is_interlaced),
    .in_last_mode     (in_last_mode),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_best_index   (out_best_index),
    .out_found        (out_found),
    .out_top_score    (out_top_score)
  );

  // Target shadow and running list state
  dim_t  tgt_w;
  dim_t  tgt_h;
  rate_t tgt_r;
  int    run_score;
  int    run_idx;
  int    list_pos;

  mode_t modes_to_send[$];
  pick_t picks_due[$];
  mode_t drv_mode;

  int    n_queued;
  int    n_taken;
  int    errors;
  int    cycles;
  int    in_wait;
  int    out_hold;
  bit    in_calm;
  bit    out_calm;
  logic  in_xfer;
  logic  out_xfer;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit rate_near(int unsigned r, int unsigned t, int unsigned win);
    return (r + win >= t) && (r <= t + win);
  endfunction

  function automatic int mode_score(mode_t m);
    int          s;
    int unsigned rr;
    int unsigned tr;
    s  = PTS_NONE;
    rr = m.r;
    tr = tgt_r;
    if (m.intl)
      return PTS_NONE;
    if (m.w == tgt_w && m.h == tgt_h) begin
      if (tr == 0)
        s = m.pref ? PTS_AUTO_PRF : PTS_FASTEST + ((rr >= RATE_CLAMP) ? RATE_CLAMP : rr);
      else if (rate_near(rr, tr, 10))
        s = PTS_EXACT;
      else if (rate_near(rr, tr, 100))
        s = PTS_NEAR;
      else if (rate_near(rr, 2 * tr, 10))
        s = PTS_DBL;
      else if (rate_near(rr, 2 * tr, 100))
        s = PTS_DBL_NEAR;
    end
    if (s <= 0 && m.pref)
      s = PTS_PREF;
    return s;
  endfunction

  // Fold one accepted mode into the running best; emit the pick on list end.
  function automatic void take_mode(mode_t m);
    int    s;
    pick_t p;
    if (list_pos < LIST_CAP) begin
      s = mode_score(m);
      if (s > run_score) begin
        run_score = s;
        run_idx   = list_pos;
      end
      list_pos++;
    end
    if (m.last) begin
      p.found = (run_score >= 0);
      p.idx   = p.found ? run_idx[5:0] : 6'd0;
      p.score = run_score[27:0];
      picks_due.push_back(p);
      run_score = PTS_NONE;
      run_idx   = 0;
      list_pos  = 0;
    end
  endfunction

  function automatic mode_t mk(int w, int h, int r, bit pref, bit intl, bit last);
    mode_t m;
    m.w    = dim_t'(w);
    m.h    = dim_t'(h);
    m.r    = rate_t'(r);
    m.pref = pref;
    m.intl = intl;
    m.last = last;
    return m;
  endfunction

  function automatic int jitter(int lo, int hi);
    int m;
    m = $urandom_range(hi, lo);
    return $urandom_range(0, 1) ? m : -m;
  endfunction

  // Bias refresh toward the window edges around the target and twice it.
  function automatic rate_t roll_rate();
    int v;
    int t;
    t = tgt_r;
    case ($urandom_range(0, 11))
      0:  v = t;
      1:  v = t + jitter(0, 10);
      2:  v = t + jitter(11, 100);
      3:  v = t + jitter(101, 150);
      4:  v = 2 * t + jitter(0, 10);
      5:  v = 2 * t + jitter(11, 100);
      6:  v = 2 * t + jitter(101, 150);
      7:  v = $urandom_range(0, RATE_MAX);
      8:  v = 0;
      9:  v = RATE_MAX;
      10: v = RATE_CLAMP + jitter(0, 2);
      default: v = $urandom_range(0, 300);
    endcase
    if (v < 0)
      v = 0;
    if (v > RATE_MAX)
      v = RATE_MAX;
    return rate_t'(v);
  endfunction

  function automatic mode_t roll_mode(bit last);
    mode_t m;
    int    sel;
    sel  = $urandom_range(0, 9);
    m.w  = tgt_w;
    m.h  = tgt_h;
    if (sel == 6)
      m.h = dim_t'($urandom);
    if (sel == 7)
      m.w = tgt_w + dim_t'(1);
    if (sel == 8) begin
      m.w = dim_t'($urandom);
      m.h = dim_t'($urandom);
    end
    if (sel == 9) begin
      m.w = '0;
      m.h = '0;
    end
    m.r    = (sel == 8 && $urandom_range(0, 1)) ? rate_t'($urandom) : roll_rate();
    m.pref = ($urandom_range(0, 3) == 0);
    m.intl = ($urandom_range(0, 5) == 0);
    m.last = last;
    return m;
  endfunction

  task automatic queue_mode(input mode_t m);
    modes_to_send.push_back(m);
    n_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [21:0] data);
    repeat ($urandom_range(0, 3)) @(negedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do
      @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    case (idx)
      CFG_TARGET_WIDTH:   tgt_w = data[13:0];
      CFG_TARGET_HEIGHT:  tgt_h = data[13:0];
      CFG_TARGET_REFRESH: tgt_r = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Upper data bits of the size registers carry random junk.
  task automatic set_targets(input int w, input int h, input int r);
    write_reg(CFG_TARGET_WIDTH, {8'($urandom), 14'(w)});
    write_reg(CFG_TARGET_HEIGHT, {8'($urandom), 14'(h)});
    write_reg(CFG_TARGET_REFRESH, 22'(r));
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (n_taken != n_queued || picks_due.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_lists(input int n_items);
    int sent;
    int len;
    int roll;
    sent = 0;
    @(posedge clk);
    #1;
    while (sent < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5)
        len = $urandom_range(LIST_CAP + 1, LIST_CAP + 8);
      else if (roll < 12)
        len = 1;
      else
        len = $urandom_range(2, 12);
      for (int k = 0; k < len; k++)
        queue_mode(roll_mode(k == len - 1));
      sent += len;
    end
    wait_drained();
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_mode_width    = '0;
    in_mode_height   = '0;
    in_mode_refresh  = '0;
    in_is_preferred  = 1'b0;
    in_is_interlaced = 1'b0;
    in_last_mode     = 1'b0;
    out_ready        = 1'b0;
    tgt_w            = '0;
    tgt_h            = '0;
    tgt_r            = '0;
    run_score        = PTS_NONE;
    run_idx          = 0;
    list_pos         = 0;
    n_queued         = 0;
    n_taken          = 0;
    errors           = 0;
    in_wait          = 0;
    out_hold         = 0;
    in_calm          = 1'b0;
    out_calm         = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Refresh windows around 60 Hz, ties, interlace and preferred fallback
    set_targets(1920, 1080, 60000);
    @(posedge clk);
    #1;
    queue_mode(mk(1920, 1080, 60000, 0, 1, 0));
    queue_mode(mk(1920, 1080, 60010, 0, 0, 0));
    queue_mode(mk(1920, 1080, 59990, 0, 0, 0));
    queue_mode(mk(1920, 1080, 59900, 0, 0, 1));
    queue_mode(mk(1280, 720, 60000, 0, 0, 1));
    queue_mode(mk(100, 100, 60000, 1, 0, 0));
    queue_mode(mk(1920, 1080, 119990, 0, 0, 0));
    queue_mode(mk(1920, 1080, 120100, 0, 0, 0));
    queue_mode(mk(1920, 1080, 60100, 0, 0, 1));
    queue_mode(mk(1920, 1080, 70000, 1, 1, 0));
    queue_mode(mk(1920, 1080, 70000, 1, 0, 0));
    queue_mode(mk(0, 0, 0, 0, 0, 1));
    queue_mode(mk(16383, 16383, RATE_MAX, 1, 0, 1));
    wait_drained();

    // Zero target refresh: preferred beats fastest, refresh saturates
    set_targets(16383, 16383, 0);
    write_reg(CFG_SPARE, 22'($urandom));
    @(posedge clk);
    #1;
    queue_mode(mk(0, 0, 0, 1, 0, 0));
    queue_mode(mk(16383, 16383, RATE_MAX, 0, 0, 0));
    queue_mode(mk(16383, 16383, 1000, 1, 0, 0));
    queue_mode(mk(16383, 16383, 0, 0, 0, 1));
    queue_mode(mk(16383, 16383, RATE_CLAMP - 1, 0, 0, 1));
    queue_mode(mk(16383, 16383, RATE_CLAMP, 0, 0, 0));
    queue_mode(mk(16383, 16383, RATE_MAX, 0, 0, 1));
    wait_drained();

    set_targets(16383, 16383, RATE_MAX);
    send_lists(218);
    set_targets(0, 0, 0);
    send_lists(218);
    set_targets($urandom_range(0, 16383), $urandom_range(0, 16383), 0);
    send_lists(218);
    set_targets(1920, 1080, 60000);
    send_lists(218);
    set_targets($urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(1, 200));
    send_lists(218);
    write_reg(CFG_SPARE, 22'($urandom));
    set_targets($urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(1, RATE_MAX));
    send_lists(218);
    set_targets(3840, 2160, RATE_MAX / 2);
    send_lists(218);
    set_targets($urandom_range(0, 16383), $urandom_range(0, 16383),
                RATE_CLAMP + jitter(0, 5));
    send_lists(218);

    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout after %0d cycles", $realtime, cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Mode driver: hold an offered mode until its transfer, then idle a while.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_xfer) begin
      end else if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (modes_to_send.size() > 0) begin
        drv_mode = modes_to_send.pop_front();
        in_mode_width    <= drv_mode.w;
        in_mode_height   <= drv_mode.h;
        in_mode_refresh  <= drv_mode.r;
        in_is_preferred  <= drv_mode.pref;
        in_is_interlaced <= drv_mode.intl;
        in_last_mode     <= drv_mode.last;
        in_valid         <= 1'b1;
        if ($urandom_range(0, 29) == 0)
          in_calm = ($urandom_range(0, 2) == 0);
        in_wait = in_calm ? 0 : $urandom_range(0, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stall a random number of cycles after each transfer.
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_xfer) begin
        if ($urandom_range(0, 19) == 0)
          out_calm = ($urandom_range(0, 2) == 0);
        out_hold = out_calm ? 0 : $urandom_range(0, 8);
      end
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pick_t want;
    if (!rst_n) begin
      in_xfer  <= 1'b0;
      out_xfer <= 1'b0;
    end else begin
      in_xfer  <= in_valid && in_ready;
      out_xfer <= out_valid && out_ready;
      if (in_valid && in_ready) begin
        take_mode(drv_mode);
        n_taken++;
      end
      if (out_valid && out_ready) begin
        if (picks_due.size() == 0) begin
          flag_mismatch("unexpected result, index", out_best_index, -1);
        end else begin
          want = picks_due.pop_front();
          if (out_best_index !== want.idx)
            flag_mismatch("best_index", out_best_index, want.idx);
          if (out_found !== want.found)
            flag_mismatch("found", out_found, want.found);
          if (out_top_score !== want.score)
            flag_mismatch("top_score", out_top_score, want.score);
        end
      end
    end
  end

endmodule

/* filelist.f */
src/dmbmp_pkg.sv
src/display_mode_best_match_picker_unit.sv
test/tb_top.sv
